### rtl/bol_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bol_pkg: shared types and constants of the bounded ordered list
// Word layouts of both channels, action and status codes, cell commands.
// ---------------------------------------------------------------------------
package bol_pkg;

    localparam int BOL_DEPTH  = 16;
    localparam int BOL_DATA_W = 16;

    localparam int ACT_W   = 4;
    localparam int VALUE_W = 16;
    localparam int POS_W   = 8;
    localparam int CNT_W   = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD_FRONT  = 4'd0,
        ACT_ADD_BACK   = 4'd1,
        ACT_INSERT     = 4'd2,
        ACT_TAKE_FRONT = 4'd3,
        ACT_TAKE_BACK  = 4'd4,
        ACT_REMOVE     = 4'd5,
        ACT_ERASE      = 4'd6,
        ACT_CLEAR      = 4'd7,
        ACT_READ       = 4'd8,
        ACT_REVERSE    = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_REM
    } cell_op_t;

    // Broadcast to every cell: what to do and at which physical slot
    typedef struct packed {
        cell_op_t         op;
        logic [POS_W-1:0] at;
    } cell_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [CNT_W-1:0]   item_count;
        status_t            status;
    } rsp_t;

endpackage

### rtl/bounded_ordered_list.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_ordered_list: double-ended ordered list of up to DEPTH entries
// Row of shifting cells under a small controller with a response register.
// ---------------------------------------------------------------------------
// Usage:
//   A request word (action, value, position) enters on req when req_valid is
//   high and req_stall is low. Each request yields exactly one response word
//   (read_value, item_count, status) on rsp in the cycle after acceptance.
//   Throughput is one request per cycle: every cell shifts, loads or holds
//   in the same cycle, and the search for an erase runs over the match flags
//   of all cells at once. The single response register sets the rate: a new
//   request is taken while that register is empty or being emptied.
//   Reverse only flips a direction flag; physical slots are renumbered
//   through it, so no entry moves.
//   When the receiver holds rsp_stall, the response word stays put and
//   req_stall rises until the word is taken.
//   Reset clears the count, the direction flag and the response valid; the
//   cell contents are left as they are and are only read after a write.
// ---------------------------------------------------------------------------
module bounded_ordered_list #(
    parameter int DEPTH  = bol_pkg::BOL_DEPTH,
    parameter int DATA_W = bol_pkg::BOL_DATA_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bol_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bol_pkg::rsp_t rsp
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int POS_W = bol_pkg::POS_W;
    localparam int VAL_W = bol_pkg::VALUE_W;
    localparam int CNT_W = bol_pkg::CNT_W;

    // control state
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             rev_reg;
    logic             rev_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    bol_pkg::rsp_t    rsp_reg;
    bol_pkg::rsp_t    rsp_next;

    logic fire;

    // cell row
    bol_pkg::cell_cmd_t cmd;
    logic [DATA_W-1:0]  in_value;
    logic [DATA_W-1:0]  cell_data [DEPTH];
    logic [DEPTH-1:0]   cell_match;

    // widened views for truncation to and from the channel widths
    logic [DATA_W+VAL_W-1:0] value_ext;
    logic [DATA_W+VAL_W-1:0] rd_ext;
    logic [OCC_W+CNT_W-1:0]  cnt_ext;

    // position arithmetic, all in channel position width
    logic [POS_W-1:0] occ8;
    logic             empty;
    logic             full;
    logic [POS_W-1:0] lp_ins;
    logic [POS_W-1:0] phys_ins;
    logic [POS_W-1:0] lp_rem;
    logic [POS_W-1:0] phys_rem;
    logic [POS_W-1:0] lp_rd;
    logic [POS_W-1:0] phys_rd;
    logic [DATA_W-1:0] rd_data;

    // erase search
    logic             hit_found;
    logic [POS_W-1:0] hit_idx;

    assign fire      = req_valid & ~req_stall;
    assign req_stall = rsp_valid_reg & rsp_stall;

    assign value_ext = {{DATA_W{1'b0}}, req.value};
    assign in_value  = value_ext[DATA_W-1:0];

    assign occ8  = POS_W'(occ_reg);
    assign empty = (occ_reg == '0);
    assign full  = (occ_reg >= OCC_W'(DEPTH));

    // logical slot for each action class, then map through the direction flag
    always_comb
    begin
        if (req.action == bol_pkg::ACT_ADD_FRONT)
            lp_ins = '0;
        else if (req.action == bol_pkg::ACT_ADD_BACK || req.position >= occ8)
            lp_ins = occ8;
        else
            lp_ins = req.position;

        if (req.action == bol_pkg::ACT_TAKE_FRONT)
            lp_rem = '0;
        else if (req.action == bol_pkg::ACT_TAKE_BACK || req.position >= occ8 - 1'b1)
            lp_rem = occ8 - 1'b1;
        else
            lp_rem = req.position;

        lp_rd = (req.position >= occ8) ? occ8 - 1'b1 : req.position;

        phys_ins = rev_reg ? occ8 - lp_ins : lp_ins;
        phys_rem = rev_reg ? occ8 - 1'b1 - lp_rem : lp_rem;
        phys_rd  = rev_reg ? occ8 - 1'b1 - lp_rd : lp_rd;
    end

    // first match in list order: lowest slot, or highest when reversed
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_match[i] && (POS_W'(i) < occ8) && (!hit_found || rev_reg))
            begin
                hit_found = 1'b1;
                hit_idx   = POS_W'(i);
            end
        end
    end

    assign rd_data = cell_data[phys_rd[PTR_W-1:0]];

    always_comb
    begin
        cmd.op   = bol_pkg::CELL_HOLD;
        cmd.at   = '0;
        occ_next = occ_reg;
        rev_next = rev_reg;
        rsp_next.status = bol_pkg::ST_OK;
        rd_ext   = '0;

        unique case (req.action)
            bol_pkg::ACT_ADD_FRONT, bol_pkg::ACT_ADD_BACK, bol_pkg::ACT_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = bol_pkg::ST_FULL;
                end
                else
                begin
                    cmd.op   = bol_pkg::CELL_INS;
                    cmd.at   = phys_ins;
                    occ_next = occ_reg + 1'b1;
                end
            end
            bol_pkg::ACT_TAKE_FRONT, bol_pkg::ACT_TAKE_BACK, bol_pkg::ACT_REMOVE:
            begin
                if (empty)
                begin
                    rsp_next.status = bol_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd.op   = bol_pkg::CELL_REM;
                    cmd.at   = phys_rem;
                    occ_next = occ_reg - 1'b1;
                end
            end
            bol_pkg::ACT_ERASE:
            begin
                if (hit_found)
                begin
                    cmd.op   = bol_pkg::CELL_REM;
                    cmd.at   = hit_idx;
                    occ_next = occ_reg - 1'b1;
                end
                else
                begin
                    rsp_next.status = bol_pkg::ST_NOT_FOUND;
                end
            end
            bol_pkg::ACT_CLEAR:
            begin
                occ_next = '0;
                rev_next = 1'b0;
            end
            bol_pkg::ACT_READ:
            begin
                if (empty)
                    rsp_next.status = bol_pkg::ST_EMPTY;
                else
                    rd_ext = {{VAL_W{1'b0}}, rd_data};
            end
            bol_pkg::ACT_REVERSE:
            begin
                rev_next = ~rev_reg;
            end
            default:
            begin
                // unused action codes leave everything alone
                rev_next = rev_reg;
            end
        endcase

        // only an accepted word may touch the cells
        if (!fire)
            cmd.op = bol_pkg::CELL_HOLD;

        cnt_ext = {{CNT_W{1'b0}}, occ_next};
        rsp_next.read_value = rd_ext[VAL_W-1:0];
        rsp_next.item_count = cnt_ext[CNT_W-1:0];

        rsp_valid_next = fire | (rsp_valid_reg & rsp_stall);
    end

    // row of cells, each linked to its neighbours; an end cell sees itself on its open side
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = cell_data[g];
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[g];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[g+1];
        end

        bol_cell #(
            .DATA_W (DATA_W),
            .IDX    (g)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .value      (in_value),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g]),
            .match      (cell_match[g])
        );
    end

    // clear count, direction and response valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            rev_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (fire)
            begin
                occ_reg <= occ_next;
                rev_reg <= rev_next;
            end
        end
    end

    // response payload: load on acceptance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (fire)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/bol_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bol_cell: one slot of the list
// Holds one entry; takes its neighbour's entry or the new value on command.
// ---------------------------------------------------------------------------
module bol_cell #(
    parameter int DATA_W = bol_pkg::BOL_DATA_W,
    parameter int IDX    = 0
) (
    input  logic                clk,
    input  bol_pkg::cell_cmd_t  cmd,
    input  logic [DATA_W-1:0]   value,
    input  logic [DATA_W-1:0]   left_data,
    input  logic [DATA_W-1:0]   right_data,
    output logic [DATA_W-1:0]   data,
    output logic                match
);

    localparam int POS_W = bol_pkg::POS_W;
    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            bol_pkg::CELL_INS:
            begin
                // slots above the insert point move up by one
                if (MY_IDX > cmd.at)
                    data_next = left_data;
                else if (MY_IDX == cmd.at)
                    data_next = value;
            end
            bol_pkg::CELL_REM:
            begin
                // slots from the removed one upwards close the gap
                if (MY_IDX >= cmd.at)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == value);

endmodule

### rtl/bol_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bol_checker: port-level checks of the bounded ordered list
// Watches both channels and flags responses that break the block's rules.
// ---------------------------------------------------------------------------
module bol_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input bol_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input bol_pkg::rsp_t rsp
);

    // every accepted word yields a response in the next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> rsp_valid)
        else $error("accepted word gave no response");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // only a read may return a value
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.action != bol_pkg::ACT_READ
        |=> rsp.read_value == '0)
        else $error("non-read returned data");

    // clear always empties the list
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.action == bol_pkg::ACT_CLEAR
        |=> rsp.item_count == '0 && rsp.status == bol_pkg::ST_OK)
        else $error("clear left entries");

    // an empty status means nothing is held
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == bol_pkg::ST_EMPTY |-> rsp.item_count == '0)
        else $error("empty status with entries held");

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

### test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for bounded_ordered_list
// A shadow queue mirrors the list and predicts every response word. Empty and
// full lists, clamped positions, undefined actions, a long receiver hold-off
// and a long random mix run under random idling, dropped in the final stretch.
// ---------------------------------------------------------------------------
module tb;

    import bol_pkg::*;

    // Action codes past reverse carry no meaning and must leave the list alone
    localparam int UNUSED_ACT_FIRST = int'(ACT_REVERSE) + 1;
    localparam int UNUSED_ACT_LAST  = (1 << ACT_W) - 1;
    localparam int POS_MAX          = (1 << POS_W) - 1;
    localparam int VALUE_MAX        = (1 << VALUE_W) - 1;

    localparam int RANDOM_WORDS     = 800;  // counted words in the random mix
    localparam int TAIL_WORDS       = 40;   // final stretch without idling
    localparam int LONG_HOLD_CYCLES = 60;   // receiver hold-off under pressure
    localparam int SETTLE_CYCLES    = 8;    // latency margin at the end

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req       = '0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    // Shadow of the list contents, front at index 0
    logic [VALUE_W-1:0] list_shadow[$];
    // Response words predicted but not yet seen on rsp
    rsp_t pending_results[$];
    int   error_count   = 0;

    // Idling control: the tail of the run drops all random gaps and stalls
    bit   quiet_phase   = 1'b0;
    int   pressure_hold = 0;    // requested hold-off, picked up by the receiver
    int   hold_left     = 0;
    int   burst_left    = 0;

    bounded_ordered_list u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predictor: apply one action to the shadow list and build its response
    // -----------------------------------------------------------------------
    function automatic rsp_t apply_list_action(input req_t w);
        rsp_t               r;
        int                 n;
        int                 at;
        int                 i;
        bit                 found;
        logic [VALUE_W-1:0] swap;
        r.read_value = '0;
        r.status     = ST_OK;
        n            = list_shadow.size();
        case (w.action)
            ACT_ADD_FRONT, ACT_ADD_BACK, ACT_INSERT:
            begin
                // Full list: drop the value and flag it
                if (n >= BOL_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (w.action == ACT_ADD_FRONT)
                        at = 0;
                    else if (w.action == ACT_ADD_BACK || int'(w.position) >= n)
                        at = n;
                    else
                        at = w.position;
                    list_shadow.insert(at, w.value);
                end
            end
            ACT_TAKE_FRONT, ACT_TAKE_BACK, ACT_REMOVE:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    if (w.action == ACT_TAKE_FRONT)
                        at = 0;
                    else if (w.action == ACT_TAKE_BACK || int'(w.position) >= n - 1)
                        at = n - 1;
                    else
                        at = w.position;
                    list_shadow.delete(at);
                end
            end
            ACT_ERASE:
            begin
                // Take out the first equal entry only
                found = 1'b0;
                for (i = 0; i < n && !found; i++)
                begin
                    if (list_shadow[i] == w.value)
                    begin
                        list_shadow.delete(i);
                        found = 1'b1;
                    end
                end
                if (!found)
                    r.status = ST_NOT_FOUND;
            end
            ACT_CLEAR:
                list_shadow.delete();
            ACT_READ:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    at           = (int'(w.position) >= n) ? n - 1 : int'(w.position);
                    r.read_value = list_shadow[at];
                end
            end
            ACT_REVERSE:
            begin
                for (i = 0; i < n / 2; i++)
                begin
                    swap                   = list_shadow[i];
                    list_shadow[i]         = list_shadow[n - 1 - i];
                    list_shadow[n - 1 - i] = swap;
                end
            end
            default:
                ;   // undefined action: list untouched, plain ok response
        endcase
        r.item_count = CNT_W'(list_shadow.size());
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Monitor: predict on every accepted request word, check every accepted
    // response word against the oldest prediction. Both channels are sampled
    // at the rising edge, before the block's own registers move.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                pending_results.insert(pending_results.size(), apply_list_action(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected response word, expected none, actual %h",
                             $time, rsp);
                end
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (rsp.read_value !== want.read_value)
                    begin
                        error_count++;
                        $display("%0t: read_value mismatch, expected %h actual %h",
                                 $time, want.read_value, rsp.read_value);
                    end
                    if (rsp.item_count !== want.item_count)
                    begin
                        error_count++;
                        $display("%0t: item_count mismatch, expected %0d actual %0d",
                                 $time, want.item_count, rsp.item_count);
                    end
                    if (rsp.status !== want.status)
                    begin
                        error_count++;
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request. Drive
    // at the falling edge.
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (pressure_hold != 0)
            begin
                hold_left     = pressure_hold;
                pressure_hold = 0;
            end
            if (hold_left != 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else if (burst_left != 0)
            begin
                rsp_stall <= 1'b1;
                burst_left--;
            end
            else if (!quiet_phase && $urandom_range(0, 6) == 0)
            begin
                // Start a stall burst of random length
                rsp_stall  <= 1'b1;
                burst_left = $urandom_range(0, 13);
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // -----------------------------------------------------------------------
    // Sender side
    // -----------------------------------------------------------------------
    function automatic req_t make_word(input int act, input int val, input int pos);
        req_t w;
        w.action   = ACT_W'(act);
        w.value    = VALUE_W'(val);
        w.position = POS_W'(pos);
        return w;
    endfunction

    // Offer one word from the falling edge and hold it until taken. Valid is
    // left high on return; the next gap or word decides what follows.
    task automatic send_word(input req_t w);
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Send with an occasional random gap ahead of the word
    task automatic offer_word(input req_t w);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        send_word(w);
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Every action but the inserts on an empty list, one undefined code included
    task automatic test_empty_list();
        offer_word(make_word(ACT_READ, VALUE_MAX, 0));
        offer_word(make_word(ACT_TAKE_FRONT, 0, 0));
        offer_word(make_word(ACT_TAKE_BACK, 0, 0));
        offer_word(make_word(ACT_REMOVE, 0, POS_MAX));
        offer_word(make_word(ACT_ERASE, 0, 0));
        offer_word(make_word(ACT_CLEAR, 0, 0));
        offer_word(make_word(ACT_REVERSE, 0, 0));
        offer_word(make_word(UNUSED_ACT_LAST, VALUE_MAX, POS_MAX));
    endtask

    // Clamping at both ends, a middle slot, reverse and erase hit or miss
    task automatic test_positions();
        offer_word(make_word(ACT_ADD_FRONT, 16'h0000, 0));
        offer_word(make_word(ACT_ADD_BACK, 16'hffff, 0));
        offer_word(make_word(ACT_INSERT, 16'h1234, POS_MAX));  // past the end: append
        offer_word(make_word(ACT_INSERT, 16'h00ff, 0));        // front
        offer_word(make_word(ACT_INSERT, 16'ha5a5, 2));        // middle
        offer_word(make_word(ACT_READ, 0, 0));
        offer_word(make_word(ACT_READ, 0, POS_MAX));
        offer_word(make_word(ACT_READ, 0, 3));
        offer_word(make_word(ACT_REVERSE, 0, 0));
        offer_word(make_word(ACT_ERASE, 16'ha5a5, 0));
        offer_word(make_word(ACT_ERASE, 16'h5a5a, 0));
        offer_word(make_word(ACT_REMOVE, 0, 0));
        offer_word(make_word(ACT_REMOVE, 0, POS_MAX));
        offer_word(make_word(ACT_REMOVE, 0, 1));
        offer_word(make_word(ACT_TAKE_FRONT, 0, 0));
        offer_word(make_word(UNUSED_ACT_FIRST, 0, 0));
    endtask

    // Hold the receiver off while words keep coming: the response register
    // fills, req_stall rises, and the list itself runs full and drops inserts
    task automatic test_backpressure_fill();
        int i;
        offer_word(make_word(ACT_CLEAR, 0, 0));
        pressure_hold = LONG_HOLD_CYCLES;
        for (i = 0; i < BOL_DEPTH + 5; i++)
            send_word(make_word($urandom_range(int'(ACT_ADD_FRONT), int'(ACT_INSERT)),
                                $urandom_range(0, VALUE_MAX),
                                $urandom_range(0, POS_MAX)));
        send_word(make_word(ACT_READ, 0, POS_MAX));
        send_word(make_word(ACT_READ, 0, BOL_DEPTH - 1));
        send_word(make_word(ACT_REVERSE, 0, 0));
        send_word(make_word(ACT_TAKE_BACK, 0, 0));
    endtask

    // One random word; growing favours inserts, otherwise removals dominate
    function automatic req_t random_word(input bit growing);
        int roll;
        int act;
        int val;
        int pos;
        roll = $urandom_range(0, 99);
        if (growing)
        begin
            if (roll < 50)      act = $urandom_range(int'(ACT_ADD_FRONT), int'(ACT_INSERT));
            else if (roll < 75) act = ACT_READ;
            else if (roll < 85) act = ACT_ERASE;
            else if (roll < 92) act = $urandom_range(int'(ACT_TAKE_FRONT), int'(ACT_REMOVE));
            else if (roll < 96) act = ACT_REVERSE;
            else if (roll < 97) act = ACT_CLEAR;
            else                act = $urandom_range(UNUSED_ACT_FIRST, UNUSED_ACT_LAST);
        end
        else
        begin
            if (roll < 20)      act = $urandom_range(int'(ACT_ADD_FRONT), int'(ACT_INSERT));
            else if (roll < 38) act = ACT_READ;
            else if (roll < 75) act = $urandom_range(int'(ACT_TAKE_FRONT), int'(ACT_REMOVE));
            else if (roll < 88) act = ACT_ERASE;
            else if (roll < 94) act = ACT_REVERSE;
            else if (roll < 96) act = ACT_CLEAR;
            else                act = $urandom_range(UNUSED_ACT_FIRST, UNUSED_ACT_LAST);
        end
        // Erase mostly targets a value that is present; small values breed
        // duplicates so first-match order matters
        if (act == ACT_ERASE && list_shadow.size() != 0 && $urandom_range(0, 9) < 7)
            val = list_shadow[$urandom_range(0, list_shadow.size() - 1)];
        else if ($urandom_range(0, 3) == 0)
            val = $urandom_range(0, 7);
        else
            val = $urandom_range(0, VALUE_MAX);
        // Positions stay near the live range, with the odd one far out
        if ($urandom_range(0, 9) == 0)
            pos = $urandom_range(0, POS_MAX);
        else
            pos = $urandom_range(0, BOL_DEPTH + 1);
        return make_word(act, val, pos);
    endfunction

    // Random mix; words with an undefined action are not counted
    task automatic test_random_mix(input int words);
        int   sent;
        bit   growing;
        req_t w;
        sent    = 0;
        growing = 1'b1;
        while (sent < words)
        begin
            // Swing between filling and draining so both ends get worked
            if ($urandom_range(0, 29) == 0)
                growing = !growing;
            w = random_word(growing);
            offer_word(w);
            if (int'(w.action) <= int'(ACT_REVERSE))
                sent++;
        end
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_positions();
        test_backpressure_fill();
        test_random_mix(RANDOM_WORDS);
        quiet_phase = 1'b1;
        test_random_mix(TAIL_WORDS);

        @(negedge clk);
        req_valid <= 1'b0;
        // Drain: every prediction must be met, then let stray words show up
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0)
            $display("bounded_ordered_list verification clean");
        else
            $display("bounded_ordered_list verification failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("bounded_ordered_list verification failed");
        $finish;
    end

endmodule
